// File: hw/rtl/sample_mean_stderror_stats_defines.svh
// Assertion macros for the per-point statistics block.
`ifndef SAMPLE_MEAN_STDERROR_STATS_DEFINES_SVH
`define SAMPLE_MEAN_STDERROR_STATS_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define SMSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define SMSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SMSS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SMSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/smss_pkg.sv
`default_nettype none
package smss_pkg;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int MAX_SAMPLES_DEF = 50;
	localparam int CNT_W = 6;
	localparam int OUT_W = 24;
	localparam int STE_W = 23;
	localparam int PF_W = 24;
	localparam int ADDR_W = 3;
	localparam int OTDATA_W = 96;
	localparam logic [PF_W-1:0] PF_RESET = 24'd65536;
	localparam logic [OUT_W-1:0] OUT_MAX = 24'h7FFFFF;
	localparam logic [OUT_W-1:0] OUT_MIN = 24'h800000;
	localparam logic [STE_W-1:0] STE_MAX = 23'h7FFFFF;
	// Register index of perturb_fraction (paddr[2]).
	localparam logic REG_PERTURB = 1'b0;
	// Flag positions in m_tuser.
	localparam int TU_COUNT_FAULT = 0;
	localparam int TU_DIVIDE_FAULT = 1;

	// Status of the point queue.
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	// Saturate a sign and magnitude value to a signed 24-bit result.
	function automatic logic [OUT_W-1:0] sat_out(input logic neg, input logic [63:0] mag);
		logic [OUT_W-1:0] r;
		if (neg) begin
			if (mag > 64'd8388608)
				r = OUT_MIN;
			else
				r = OUT_W'(~mag + 64'd1);
		end else begin
			if (mag > 64'd8388607)
				r = OUT_MAX;
			else
				r = mag[OUT_W-1:0];
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// File: hw/rtl/sample_mean_stderror_stats.sv
// Per-point sample mean and standard error, Q8.16 fixed point.
// Input channel s_*: one sample per item, s_tlast marks the last sample of a point.
// Samples accumulate at one item per cycle; s_tready drops only while the two-entry
// queue of closed points is full.
// Output channel m_*: one result per closed point: mean, standard error, error-
// weighted mean and unreliability in m_tdata, fault flags in m_tuser.
// Each point is finished by one shared restoring divider (one bit per cycle) and a
// two-bit-per-cycle square root: up to four divisions of DW-bit operands plus DW/2
// root steps, DW = SAMPLE_BITS+36 rounded up to even. A point with a count fault
// skips the divider and the root.
// A result is held in the output register until m_tready; meanwhile up to two
// more closed points queue up and samples keep arriving until the queue is full.
// perturb_fraction sits at APB address 0, write it only while the block is idle.
// Reset clears the accumulators, the queue and the output valid, and loads
// perturb_fraction with 1.0.
`default_nettype none
`include "sample_mean_stderror_stats_defines.svh"
module sample_mean_stderror_stats #(
	parameter int SAMPLE_BITS = smss_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_SAMPLES = smss_pkg::MAX_SAMPLES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [smss_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  wire logic s_tvalid,
	output logic s_tready,
	// [SAMPLE_BITS-1:0] sample, zero padded to whole bytes
	input  wire logic [8*((SAMPLE_BITS+7)/8)-1:0] s_tdata,
	input  wire logic s_tlast,
	output logic m_tvalid,
	input  wire logic m_tready,
	// [23:0] mean_value, [46:24] std_error, [70:47] weighted_mean,
	// [94:71] unreliability, [95] zero
	output logic [smss_pkg::OTDATA_W-1:0] m_tdata,
	// [0] count_fault, [1] divide_fault
	output logic [1:0] m_tuser
);
	localparam int SUMW = SAMPLE_BITS + 6;
	localparam int SQW = 2 * SAMPLE_BITS + 6;
	localparam int EW = SUMW + SQW + smss_pkg::CNT_W + 1;

	logic [smss_pkg::PF_W-1:0] pf_q;
	smss_pkg::q_status_t qstat;
	logic push, pop;
	logic [SUMW-1:0] f_sum, b_sum;
	logic [SQW-1:0] f_sq, b_sq;
	logic [smss_pkg::CNT_W-1:0] f_cnt, b_cnt;
	logic f_fault, b_fault;
	logic [EW-1:0] q_dout;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == smss_pkg::REG_PERTURB) ? 32'(pf_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pf_q <= smss_pkg::PF_RESET;
		else if (psel && penable && pwrite && paddr[2] == smss_pkg::REG_PERTURB)
			pf_q <= pwdata[smss_pkg::PF_W-1:0];
	end

	smss_front #(.SAMPLE_BITS(SAMPLE_BITS), .MAX_SAMPLES(MAX_SAMPLES)) u_front (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.sample(s_tdata[SAMPLE_BITS-1:0]), .last_sample(s_tlast), .qstat(qstat),
		.push(push), .e_sum(f_sum), .e_sq(f_sq), .e_cnt(f_cnt), .e_fault(f_fault)
	);

	smss_queue #(.W(EW)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .din({f_fault, f_cnt, f_sq, f_sum}),
		.pop(pop), .dout(q_dout), .qstat(qstat)
	);

	assign {b_fault, b_cnt, b_sq, b_sum} = q_dout;

	smss_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .qstat(qstat), .e_sum(b_sum), .e_sq(b_sq),
		.e_cnt(b_cnt), .e_fault(b_fault), .pop(pop), .perturb_fraction(pf_q),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// A count fault clears every other field of the result.
	`SMSS_ASSERT_IMPL(a_count_fault_zero, clk, arst_n,
		m_tvalid && m_tuser[smss_pkg::TU_COUNT_FAULT],
		m_tdata == '0 && !m_tuser[smss_pkg::TU_DIVIDE_FAULT])
	// Zero standard error gives zero unreliability and no divide fault.
	`SMSS_ASSERT_IMPL(a_zero_ste, clk, arst_n,
		m_tvalid && !m_tuser[smss_pkg::TU_COUNT_FAULT] && m_tdata[46:24] == '0,
		m_tdata[94:71] == '0 && !m_tuser[smss_pkg::TU_DIVIDE_FAULT])
	// The back end never pops while a result is still waiting.
	`SMSS_ASSERT_NEXT(a_no_pop_pending, clk, arst_n,
		m_tvalid && !m_tready, !pop)
endmodule
`default_nettype wire

// File: hw/rtl/smss_front.sv
`default_nettype none
module smss_front #(
	parameter int SAMPLE_BITS = smss_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_SAMPLES = smss_pkg::MAX_SAMPLES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	input  wire logic last_sample,
	input  wire smss_pkg::q_status_t qstat,
	output logic push,
	output logic [SAMPLE_BITS+5:0] e_sum,
	output logic [2*SAMPLE_BITS+5:0] e_sq,
	output logic [smss_pkg::CNT_W-1:0] e_cnt,
	output logic e_fault
);
	localparam int SUMW = SAMPLE_BITS + 6;
	localparam int SQW = 2 * SAMPLE_BITS + 6;

	logic signed [SUMW-1:0] sum_q;
	logic [SQW-1:0] sq_q;
	logic [smss_pkg::CNT_W-1:0] seen_q;
	logic ovf_q;
	logic accept, take;
	logic signed [2*SAMPLE_BITS-1:0] prod;

	assign s_tready = !qstat.full;
	assign accept = s_tvalid && s_tready;
	assign push = accept && last_sample;
	assign take = seen_q < smss_pkg::CNT_W'(MAX_SAMPLES);
	assign prod = $signed(sample) * $signed(sample);

	// Next running totals, including the sample being taken.
	always_comb begin
		e_sum = sum_q;
		e_sq = sq_q;
		e_cnt = seen_q;
		if (take) begin
			e_sum = sum_q + SUMW'($signed(sample));
			e_sq = sq_q + SQW'(prod);
			e_cnt = seen_q + smss_pkg::CNT_W'(1);
		end
		e_fault = ovf_q || !take || (e_cnt < smss_pkg::CNT_W'(2));
	end

	// Accumulators; a closing item hands the point over and clears them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			sq_q <= '0;
			seen_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (last_sample) begin
				sum_q <= '0;
				sq_q <= '0;
				seen_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				sum_q <= e_sum;
				sq_q <= e_sq;
				seen_q <= e_cnt;
				ovf_q <= ovf_q || !take;
			end
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/smss_queue.sv
`default_nettype none
module smss_queue #(
	parameter int W = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire logic [W-1:0] din,
	input  wire logic pop,
	output logic [W-1:0] dout,
	output smss_pkg::q_status_t qstat
);
	logic [W-1:0] ent_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	assign dout = ent_q[rd_q];
	assign qstat.empty = (cnt_q == 2'd0);
	assign qstat.full = (cnt_q == 2'd2);

	// Two-entry queue of closed points.
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/smss_div.sv
`default_nettype none
module smss_div #(
	parameter int DW = 60
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [DW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic done,
	output logic [DW-1:0] quo
);
	localparam int IW = $clog2(DW);

	logic busy_q, done_q;
	logic [IW-1:0] it_q;
	logic [DW-1:0] rem_q, quo_q, den_q;
	logic [DW:0] rem_sh;
	logic ge;

	assign rem_sh = {rem_q, quo_q[DW-1]};
	assign ge = rem_sh >= {1'b0, den_q};
	assign done = done_q;
	assign quo = quo_q;

	// Restoring division, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				it_q <= '0;
			end else if (busy_q) begin
				it_q <= it_q + IW'(1);
				if (it_q == IW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/smss_back.sv
`default_nettype none
module smss_back #(
	parameter int SAMPLE_BITS = smss_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire smss_pkg::q_status_t qstat,
	input  wire logic [SAMPLE_BITS+5:0] e_sum,
	input  wire logic [2*SAMPLE_BITS+5:0] e_sq,
	input  wire logic [smss_pkg::CNT_W-1:0] e_cnt,
	input  wire logic e_fault,
	output logic pop,
	input  wire logic [smss_pkg::PF_W-1:0] perturb_fraction,
	output logic m_tvalid,
	input  wire logic m_tready,
	output logic [smss_pkg::OTDATA_W-1:0] m_tdata,
	output logic [1:0] m_tuser
);
	localparam int SB = SAMPLE_BITS;
	localparam int SUMW = SB + 6;
	localparam int SQW = 2 * SB + 6;
	localparam int DW = 2 * ((SB + 37) / 2);
	localparam int RTW = DW / 2;
	localparam int RIW = $clog2(RTW);
	localparam int MMW = 2 * SB + 2;
	localparam int PW = 2 * SB + 8;
	localparam int D1W = RTW + 2;
	localparam int D2W = DW + 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MEAN, ST_SQR, ST_MS, ST_VAR, ST_SQRT, ST_PREP,
		ST_WMS, ST_WM, ST_UNS, ST_UN, ST_FIN, ST_OUT
	} state_t;

	state_t state_q;
	logic [smss_pkg::CNT_W-1:0] cnt_q;
	logic [SQW-1:0] sq_q;
	logic signed [SB:0] mean_q;
	logic [MMW-1:0] mm_q;
	logic [DW-1:0] x_q;
	logic [RTW+1:0] rem_q;
	logic [RTW-1:0] root_q;
	logic [RIW-1:0] it_q;
	logic signed [D1W-1:0] d1_q;
	logic signed [D2W-1:0] d2_q;
	logic [smss_pkg::OUT_W-1:0] wm_q, un_q;
	logic df_q, neg_q;
	logic div_start_q;
	logic [DW-1:0] div_num_q, div_den_q;
	logic div_done;
	logic [DW-1:0] div_quo;
	logic m_tvalid_q;
	logic [smss_pkg::OTDATA_W-1:0] m_tdata_q;
	logic [1:0] m_tuser_q;

	logic [SB:0] qmean;
	logic signed [MMW-1:0] msq;
	logic [PW-1:0] mprod;
	logic signed [DW:0] ms;
	logic [DW-1:0] ms_abs;
	logic [RTW+3:0] rem_n, trial;
	logic trial_ok;
	logic signed [D1W-1:0] d1;
	logic signed [D2W-1:0] pmul, d2;
	logic [SUMW-1:0] sum_abs;
	logic [SB:0] mean_abs;
	logic [D1W-1:0] d1_abs;
	logic [D2W-1:0] d2_abs;
	logic [smss_pkg::STE_W-1:0] ste_out;
	logic [RTW+31:0] ste_sh;

	smss_div #(.DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q), .num(div_num_q),
		.den(div_den_q), .done(div_done), .quo(div_quo)
	);

	assign pop = (state_q == ST_IDLE) && !qstat.empty;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	// Datapath pieces used by the sequencer.
	always_comb begin
		qmean = div_quo[SB:0];
		sum_abs = e_sum[SUMW-1] ? SUMW'(-e_sum) : e_sum;
		msq = mean_q * mean_q;
		mprod = PW'(cnt_q) * PW'(mm_q);
		ms = $signed({1'b0, DW'(sq_q)}) - $signed({1'b0, DW'(mprod)});
		ms_abs = ms[DW] ? DW'(-ms) : ms[DW-1:0];
		rem_n = {rem_q, x_q[DW-1:DW-2]};
		trial = {2'b00, root_q, 2'b01};
		trial_ok = rem_n >= trial;
		d1 = D1W'(mean_q) + $signed({2'b00, root_q});
		pmul = D2W'($signed({1'b0, perturb_fraction}) * mean_q);
		d2 = pmul + $signed(D2W'({root_q, 16'b0}));
		mean_abs = mean_q[SB] ? (SB+1)'(-mean_q) : mean_q;
		d1_abs = d1_q[D1W-1] ? D1W'(-d1_q) : d1_q;
		d2_abs = d2_q[D2W-1] ? D2W'(-d2_q) : d2_q;
		ste_out = (root_q > RTW'(smss_pkg::STE_MAX)) ? smss_pkg::STE_MAX
			: root_q[smss_pkg::STE_W-1:0];
		ste_sh = {root_q, 32'b0};
	end

	// Sequencer: mean, variance, root, quotients, unless count fault.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_start_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tuser_q <= '0;
		end else begin
			div_start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!qstat.empty) begin
						cnt_q <= e_cnt;
						sq_q <= e_sq;
						if (e_fault) begin
							m_tdata_q <= '0;
							m_tuser_q <= 2'b01 << smss_pkg::TU_COUNT_FAULT;
							m_tvalid_q <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							neg_q <= e_sum[SUMW-1];
							div_num_q <= DW'(sum_abs);
							div_den_q <= DW'(e_cnt);
							div_start_q <= 1'b1;
							state_q <= ST_MEAN;
						end
					end
				end
				ST_MEAN: begin
					if (div_done) begin
						mean_q <= neg_q ? $signed(-qmean) : $signed(qmean);
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					mm_q <= msq;
					state_q <= ST_MS;
				end
				ST_MS: begin
					div_num_q <= ms_abs;
					div_den_q <= DW'(cnt_q - smss_pkg::CNT_W'(1));
					div_start_q <= 1'b1;
					state_q <= ST_VAR;
				end
				ST_VAR: begin
					if (div_done) begin
						x_q <= div_quo;
						rem_q <= '0;
						root_q <= '0;
						it_q <= '0;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					x_q <= {x_q[DW-3:0], 2'b00};
					rem_q <= trial_ok ? (RTW+2)'(rem_n - trial) : rem_n[RTW+1:0];
					root_q <= {root_q[RTW-2:0], trial_ok};
					it_q <= it_q + RIW'(1);
					if (it_q == RIW'(RTW - 1))
						state_q <= ST_PREP;
				end
				ST_PREP: begin
					df_q <= 1'b0;
					d1_q <= d1;
					d2_q <= d2;
					if (root_q == '0) begin
						wm_q <= smss_pkg::sat_out(mean_q[SB], 64'(mean_abs));
						un_q <= '0;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_WMS;
					end
				end
				ST_WMS: begin
					if (d1_q == '0) begin
						wm_q <= smss_pkg::OUT_MAX;
						df_q <= 1'b1;
						state_q <= ST_UNS;
					end else begin
						neg_q <= d1_q[D1W-1];
						div_num_q <= DW'(mm_q);
						div_den_q <= DW'(d1_abs);
						div_start_q <= 1'b1;
						state_q <= ST_WM;
					end
				end
				ST_WM: begin
					if (div_done) begin
						wm_q <= smss_pkg::sat_out(neg_q, 64'(div_quo));
						state_q <= ST_UNS;
					end
				end
				ST_UNS: begin
					if (d2_q == '0) begin
						un_q <= smss_pkg::OUT_MAX;
						df_q <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						neg_q <= d2_q[D2W-1];
						div_num_q <= ste_sh[DW-1:0];
						div_den_q <= d2_abs[DW-1:0];
						div_start_q <= 1'b1;
						state_q <= ST_UN;
					end
				end
				ST_UN: begin
					if (div_done) begin
						un_q <= smss_pkg::sat_out(neg_q, 64'(div_quo));
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					m_tdata_q <= {1'b0, un_q, wm_q, ste_out,
						smss_pkg::sat_out(mean_q[SB], 64'(mean_abs))};
					m_tuser_q <= {df_q, 1'b0};
					m_tvalid_q <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
